[hw/rtl/fal_pkg.sv]
// Shared types and codes for the fixed-capacity array list engine.
// Used by fal_ctrl and fixed_array_list_engine_top; depends on nothing.
package fal_pkg;

  localparam logic [3:0] REQ_INS_END   = 4'd0;
  localparam logic [3:0] REQ_INS_START = 4'd1;
  localparam logic [3:0] REQ_INS_AT    = 4'd2;
  localparam logic [3:0] REQ_REM_END   = 4'd3;
  localparam logic [3:0] REQ_REM_START = 4'd4;
  localparam logic [3:0] REQ_REM_AT    = 4'd5;
  localparam logic [3:0] REQ_CLEAR     = 4'd6;
  localparam logic [3:0] REQ_SORT      = 4'd7;
  localparam logic [3:0] REQ_READ      = 4'd8;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  // One result item as produced by the sequencer.
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic signed [31:0] rdata;
    logic [3:0]         count;
  } rsp_t;

endpackage

[hw/rtl/fal_mem.sv]
// Entry storage of the array list: one write port, one read port with
// registered read data. No dependencies.
module fal_mem #(
  parameter int Depth = 8,
  parameter int AddrW = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fal_ctrl.sv]
// Sequencer of the array list: decodes a request, walks the entry memory
// one entry at a time with a single comparator, and keeps the entry count.
// Depends on fal_pkg.
module fal_ctrl #(
  parameter int Capacity = 8,
  parameter int IdxW     = 3,
  parameter int CntW     = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [3:0]       req_type_i,
  input  logic [31:0]      value_i,
  input  logic [2:0]       position_i,
  output logic             busy_o,
  output logic             mem_we_o,
  output logic [IdxW-1:0]  mem_waddr_o,
  output logic [31:0]      mem_wdata_o,
  output logic [IdxW-1:0]  mem_raddr_o,
  input  logic [31:0]      mem_rdata_i,
  output fal_pkg::rsp_t    rsp_o
);

  localparam int PW  = (CntW > 3) ? CntW : 3;
  localparam int CW4 = (CntW > 4) ? CntW : 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN_RD,
    S_OPEN_WR,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_SORT_LD,
    S_SORT_LW,
    S_SORT_RD,
    S_SORT_CMP,
    S_READ_WAIT
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic [IdxW-1:0]   at_q, at_d;
  logic [CntW-1:0]   b_q, b_d;
  logic [31:0]       cur_q, cur_d;
  logic [31:0]       val_q, val_d;

  logic              full, empty, pos_ok, swap;
  logic [PW-1:0]     pos_ext;
  logic [IdxW-1:0]   pos_idx, cnt_idx;
  logic [CW4-1:0]    cnt_ext;
  logic              rsp_valid;
  fal_pkg::status_e  rsp_status;
  logic [31:0]       rsp_rdata;

  assign full    = (count_q == CntW'(Capacity));
  assign empty   = (count_q == '0);
  assign pos_ext = PW'(position_i);
  assign pos_ok  = (pos_ext < PW'(count_q));
  assign pos_idx = pos_ext[IdxW-1:0];
  assign cnt_idx = count_q[IdxW-1:0];
  // The shared comparator of the sort pass.
  assign swap    = ($signed(cur_q) > $signed(mem_rdata_i));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    at_d        = at_q;
    b_d         = b_q;
    cur_d       = cur_q;
    val_d       = val_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;
    rsp_valid   = 1'b0;
    rsp_status  = fal_pkg::ST_OK;
    rsp_rdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = value_i;
          unique case (req_type_i) inside
            fal_pkg::REQ_INS_END, fal_pkg::REQ_INS_START, fal_pkg::REQ_INS_AT: begin
              if (full) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_FULL;
              end else if (req_type_i == fal_pkg::REQ_INS_END) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_idx;
                mem_wdata_o = value_i;
                count_d     = count_q + 1'b1;
                rsp_valid   = 1'b1;
              end else if (req_type_i == fal_pkg::REQ_INS_AT && !pos_ok) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_BADIDX;
              end else begin
                k_d     = cnt_idx;
                at_d    = (req_type_i == fal_pkg::REQ_INS_AT) ? pos_idx : '0;
                state_d = S_OPEN_RD;
              end
            end
            fal_pkg::REQ_REM_END, fal_pkg::REQ_REM_START, fal_pkg::REQ_REM_AT: begin
              if (empty) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_EMPTY;
              end else if (req_type_i == fal_pkg::REQ_REM_END) begin
                count_d   = count_q - 1'b1;
                rsp_valid = 1'b1;
              end else if (req_type_i == fal_pkg::REQ_REM_AT && !pos_ok) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_BADIDX;
              end else begin
                k_d     = (req_type_i == fal_pkg::REQ_REM_AT) ? pos_idx : '0;
                state_d = S_CLOSE_RD;
              end
            end
            fal_pkg::REQ_CLEAR: begin
              count_d   = '0;
              rsp_valid = 1'b1;
            end
            fal_pkg::REQ_SORT: begin
              if (empty) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_EMPTY;
              end else if (count_q == CntW'(1)) begin
                rsp_valid = 1'b1;
              end else begin
                at_d    = '0;
                state_d = S_SORT_LD;
              end
            end
            fal_pkg::REQ_READ: begin
              if (empty) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_EMPTY;
              end else if (!pos_ok) begin
                rsp_valid  = 1'b1;
                rsp_status = fal_pkg::ST_BADIDX;
              end else begin
                mem_raddr_o = pos_idx;
                state_d     = S_READ_WAIT;
              end
            end
            default: begin
              rsp_valid = 1'b1;
            end
          endcase
        end
      end

      // Shift entries up from the top, one per read/write pair, then drop
      // the new value into the opened slot.
      S_OPEN_RD: begin
        if (k_q == at_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = at_q;
          mem_wdata_o = val_q;
          count_d     = count_q + 1'b1;
          rsp_valid   = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_raddr_o = k_q - 1'b1;
          state_d     = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = mem_rdata_i;
        k_d         = k_q - 1'b1;
        state_d     = S_OPEN_RD;
      end

      // Pull entries down over the removed slot.
      S_CLOSE_RD: begin
        if ((CntW'(k_q) + 1'b1) >= count_q) begin
          count_d   = count_q - 1'b1;
          rsp_valid = 1'b1;
          state_d   = S_IDLE;
        end else begin
          mem_raddr_o = k_q + 1'b1;
          state_d     = S_CLOSE_WR;
        end
      end
      S_CLOSE_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = mem_rdata_i;
        k_d         = k_q + 1'b1;
        state_d     = S_CLOSE_RD;
      end

      // Exchange sort: cur_q holds the running minimum for slot at_q. A
      // larger holder is swapped into slot b_q, which matches the pairwise
      // exchanges of the textbook form.
      S_SORT_LD: begin
        mem_raddr_o = at_q;
        state_d     = S_SORT_LW;
      end
      S_SORT_LW: begin
        cur_d   = mem_rdata_i;
        b_d     = CntW'(at_q) + 1'b1;
        state_d = S_SORT_RD;
      end
      S_SORT_RD: begin
        if (b_q >= count_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = at_q;
          mem_wdata_o = cur_q;
          if ((CntW'(at_q) + CntW'(2)) >= count_q) begin
            rsp_valid = 1'b1;
            state_d   = S_IDLE;
          end else begin
            at_d    = at_q + 1'b1;
            state_d = S_SORT_LD;
          end
        end else begin
          mem_raddr_o = b_q[IdxW-1:0];
          state_d     = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (swap) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = b_q[IdxW-1:0];
          mem_wdata_o = cur_q;
          cur_d       = mem_rdata_i;
        end
        b_d     = b_q + 1'b1;
        state_d = S_SORT_RD;
      end

      S_READ_WAIT: begin
        rsp_valid = 1'b1;
        rsp_rdata = mem_rdata_i;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cnt_ext = CW4'(count_d);

  always_comb begin
    rsp_o.valid  = rsp_valid;
    rsp_o.status = rsp_status;
    rsp_o.rdata  = rsp_rdata;
    rsp_o.count  = cnt_ext[3:0];
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    at_q  <= at_d;
    b_q   <= b_d;
    cur_q <= cur_d;
    val_q <= val_d;
  end

endmodule

[hw/rtl/fixed_array_list_engine_top.sv]
// Top level of the fixed-capacity array list engine: sequencer, entry
// memory and the registered result port. Depends on fal_pkg, fal_mem, fal_ctrl.
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy             req_type_i, value_i, position_i
//  result    out        done_o (one cycle)        status_o, read_value_o, count_o
//
// A request is taken when start is high and busy is low; its result shows on
// done_o in the cycle after the sequencer finishes. Clear, end insert/remove,
// failed and unknown requests finish in the cycle they are taken, and a read
// waits for the registered memory data. Insert and remove at the start or at an
// index shift entries one read/write pair at a time. rst_ni empties the list
// asynchronously. The receiver cannot stall.
module fixed_array_list_engine_top #(
  parameter int CAPACITY = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic [2:0]         position_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic [3:0]         count_o
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata, mem_rdata;
  fal_pkg::rsp_t   rsp;

  logic               done_q;
  fal_pkg::status_e   status_q;
  logic signed [31:0] rdata_q;
  logic [3:0]         count_q;

  fal_ctrl #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .busy_o      (busy),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .rsp_o       (rsp)
  );

  fal_mem #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register; payload is loaded only when a result is produced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.valid) begin
      status_q <= rsp.status;
      rdata_q  <= rsp.rdata;
      count_q  <= rsp.count;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdata_q;
  assign count_o      = count_q;

endmodule

[verif/tb.sv]
// Self-checking testbench for fixed_array_list_engine_top: directed and random list
// requests, each result checked against a shadow copy of the list kept in the bench.
// Depends on fal_pkg and the RTL under hw/rtl.
module tb;

  localparam int         CAPACITY     = 8;
  localparam int         RANDOM_ITEMS = 400;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 200;
  localparam int         MAX_REPORTS  = 10;
  localparam logic [3:0] REQ_SPARE_LO = 4'd9;
  localparam logic [3:0] REQ_SPARE_HI = 4'd15;
  localparam logic [2:0] POS_FIRST    = 3'd0;
  localparam logic [2:0] POS_LAST     = 3'd7;

  typedef struct {
    logic [3:0]         req;
    logic signed [31:0] val;
    logic [2:0]         pos;
  } list_request_t;

  typedef struct {
    fal_pkg::status_e   status;
    logic signed [31:0] rdata;
    logic [3:0]         count;
  } list_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic [3:0]         req_type_i   = '0;
  logic signed [31:0] value_i      = '0;
  logic [2:0]         position_i   = '0;
  logic               busy;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [3:0]         count_o;

  list_request_t      pending_requests[$];
  list_result_t       awaited_results[$];
  logic signed [31:0] shadow_list[CAPACITY];
  int                 shadow_len     = 0;
  int                 planned_len    = 0;
  int                 requests_taken = 0;
  int                 results_seen   = 0;
  int                 mismatches     = 0;
  int                 cycles         = 0;
  int                 status_seen[4] = '{0, 0, 0, 0};

  fixed_array_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  always #6 clk_i = ~clk_i;

  // Applies one request to the shadow list and returns the result it should produce.
  function automatic list_result_t apply_to_shadow_list(logic [3:0] req,
                                                       logic signed [31:0] val,
                                                       logic [2:0] pos);
    list_result_t       r;
    logic signed [31:0] swap;
    int                 at;
    r.status = fal_pkg::ST_OK;
    r.rdata  = '0;
    case (req) inside
      fal_pkg::REQ_INS_END, fal_pkg::REQ_INS_START, fal_pkg::REQ_INS_AT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = fal_pkg::ST_FULL;
        end else if (req == fal_pkg::REQ_INS_AT && int'(pos) >= shadow_len) begin
          r.status = fal_pkg::ST_BADIDX;
        end else begin
          at = (req == fal_pkg::REQ_INS_END) ? shadow_len :
               (req == fal_pkg::REQ_INS_START) ? 0 : int'(pos);
          for (int k = shadow_len; k > at; k--) shadow_list[k] = shadow_list[k - 1];
          shadow_list[at] = val;
          shadow_len++;
        end
      end
      fal_pkg::REQ_REM_END, fal_pkg::REQ_REM_START, fal_pkg::REQ_REM_AT: begin
        if (shadow_len == 0) begin
          r.status = fal_pkg::ST_EMPTY;
        end else if (req == fal_pkg::REQ_REM_AT && int'(pos) >= shadow_len) begin
          r.status = fal_pkg::ST_BADIDX;
        end else begin
          at = (req == fal_pkg::REQ_REM_END) ? shadow_len - 1 :
               (req == fal_pkg::REQ_REM_START) ? 0 : int'(pos);
          for (int k = at; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_len--;
        end
      end
      fal_pkg::REQ_CLEAR: shadow_len = 0;
      fal_pkg::REQ_SORT: begin
        if (shadow_len == 0) begin
          r.status = fal_pkg::ST_EMPTY;
        end else begin
          for (int a = 0; a < shadow_len; a++) begin
            for (int b = a + 1; b < shadow_len; b++) begin
              if (shadow_list[a] > shadow_list[b]) begin
                swap           = shadow_list[a];
                shadow_list[a] = shadow_list[b];
                shadow_list[b] = swap;
              end
            end
          end
        end
      end
      fal_pkg::REQ_READ: begin
        if (shadow_len == 0) r.status = fal_pkg::ST_EMPTY;
        else if (int'(pos) >= shadow_len) r.status = fal_pkg::ST_BADIDX;
        else r.rdata = shadow_list[pos];
      end
      default: ;
    endcase
    r.count = shadow_len[3:0];
    return r;
  endfunction

  // Queues a request and tracks the list length it will leave, so that random positions
  // can be aimed at existing entries.
  task automatic queue_request(logic [3:0] req, logic signed [31:0] val, logic [2:0] pos);
    list_request_t item;
    item.req = req;
    item.val = val;
    item.pos = pos;
    pending_requests.push_back(item);
    case (req) inside
      fal_pkg::REQ_INS_END, fal_pkg::REQ_INS_START, fal_pkg::REQ_INS_AT:
        if (planned_len < CAPACITY &&
            (req != fal_pkg::REQ_INS_AT || int'(pos) < planned_len))
          planned_len++;
      fal_pkg::REQ_REM_END, fal_pkg::REQ_REM_START, fal_pkg::REQ_REM_AT:
        if (planned_len > 0 && (req != fal_pkg::REQ_REM_AT || int'(pos) < planned_len))
          planned_len--;
      fal_pkg::REQ_CLEAR: planned_len = 0;
      default: ;
    endcase
  endtask

  // Request driver. The idle gaps are switched off for a long stretch in the middle.
  always @(posedge clk_i) begin : drive_requests
    logic          present_next;
    logic          may_idle;
    list_request_t item;
    cycles++;
    if (rst_ni) begin
      present_next = !start;
      if (start && !busy) begin
        awaited_results.push_back(apply_to_shadow_list(req_type_i, value_i, position_i));
        requests_taken++;
        present_next = 1'b1;
      end
      if (present_next) begin
        may_idle = requests_taken < 150 || requests_taken > 260;
        if (pending_requests.size() > 0 && !(may_idle && $urandom_range(99) < 35)) begin
          item = pending_requests.pop_front();
          start      <= 1'b1;
          req_type_i <= item.req;
          value_i    <= item.val;
          position_i <= item.pos;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result status=%0d value=%0d count=%0d",
                   status_o, read_value_o, count_o);
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        status_seen[status_o]++;
        if (status_o !== want.status || read_value_o !== want.rdata ||
            count_o !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"ERROR: result %0d expected status=%0d value=%0d count=%0d,",
                      " got status=%0d value=%0d count=%0d"},
                     results_seen, want.status, want.rdata, want.count,
                     status_o, read_value_o, count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles with %0d results outstanding",
               cycles, awaited_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0]         req;
    logic signed [31:0] val;
    logic [2:0]         pos;
    int                 pick;

    // Empty list: every request that needs an entry must be refused.
    queue_request(fal_pkg::REQ_READ, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_SORT, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_REM_END, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_REM_START, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_REM_AT, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_AT, 32'sd5, POS_FIRST);
    // Fill to capacity with extreme values and all three insert forms, overfill, then sort.
    queue_request(fal_pkg::REQ_INS_END, 32'sh7FFF_FFFF, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_START, 32'sh8000_0000, POS_LAST);
    queue_request(fal_pkg::REQ_INS_AT, -32'sd1, 3'd1);
    queue_request(fal_pkg::REQ_READ, 32'sd0, 3'd5);
    queue_request(fal_pkg::REQ_INS_END, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_END, 32'sd1, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_START, 32'sd5, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_AT, 32'sd42, 3'd5);
    queue_request(fal_pkg::REQ_INS_END, -32'sd7, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_END, 32'sd9, POS_FIRST);
    queue_request(fal_pkg::REQ_INS_AT, 32'sd3, POS_LAST);
    queue_request(fal_pkg::REQ_INS_START, 32'sd3, POS_FIRST);
    queue_request(fal_pkg::REQ_READ, 32'sd0, POS_LAST);
    queue_request(fal_pkg::REQ_SORT, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_READ, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_READ, 32'sd0, POS_LAST);
    // Removal at the last slot, then at the same slot once it is past the end.
    queue_request(fal_pkg::REQ_REM_AT, 32'sd0, POS_LAST);
    queue_request(fal_pkg::REQ_REM_AT, 32'sd0, POS_LAST);
    queue_request(fal_pkg::REQ_REM_START, 32'sd0, POS_FIRST);
    queue_request(fal_pkg::REQ_REM_END, 32'sd0, POS_FIRST);
    queue_request(REQ_SPARE_LO, 32'sd0, POS_FIRST);
    queue_request(REQ_SPARE_HI, -32'sd1, POS_LAST);
    queue_request(fal_pkg::REQ_CLEAR, 32'sd0, POS_FIRST);

    // Mostly inserts, removals and reads aimed at existing entries, with small values
    // so that sorting sees duplicates.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < ((planned_len == CAPACITY) ? 15 : 45))
        req = 4'($urandom_range(fal_pkg::REQ_INS_END, fal_pkg::REQ_INS_AT));
      else if (pick < 72)
        req = 4'($urandom_range(fal_pkg::REQ_REM_END, fal_pkg::REQ_REM_AT));
      else if (pick < 88)
        req = fal_pkg::REQ_READ;
      else if (pick < 94)
        req = fal_pkg::REQ_SORT;
      else if (pick < 96)
        req = fal_pkg::REQ_CLEAR;
      else
        req = 4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      pick = $urandom_range(99);
      if (pick < 12)
        case ($urandom_range(3))
          0: val = 32'sh7FFF_FFFF;
          1: val = 32'sh8000_0000;
          2: val = 32'sd0;
          default: val = -32'sd1;
        endcase
      else if (pick < 55)
        val = $signed(32'($urandom_range(20))) - 32'sd10;
      else
        val = $signed($urandom);
      if (planned_len > 0 && $urandom_range(99) < 80)
        pos = 3'($urandom_range(planned_len - 1));
      else
        pos = 3'($urandom_range(7));
      queue_request(req, val, pos);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() > 0 || start || awaited_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Requests accepted: %0d, results checked: %0d, mismatches: %0d",
             requests_taken, results_seen, mismatches);
    $display("Status mix: ok %0d, full %0d, empty %0d, bad index %0d",
             status_seen[fal_pkg::ST_OK], status_seen[fal_pkg::ST_FULL],
             status_seen[fal_pkg::ST_EMPTY], status_seen[fal_pkg::ST_BADIDX]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/fal_pkg.sv
hw/rtl/fal_mem.sv
hw/rtl/fal_ctrl.sv
hw/rtl/fixed_array_list_engine_top.sv
verif/tb.sv
